[hw/rtl/cfd_pkg.sv]
package cfd_pkg;

  // Frame buffer size in bytes; the store keeps one byte less than this.
  localparam int BUFFER_BYTES = 64;
  localparam int STORE_DEPTH  = BUFFER_BYTES - 1;
  localparam int FILL_W       = $clog2(BUFFER_BYTES);
  localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 6;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int MASK_WORDS   = 4;

  localparam logic [BYTE_W-1:0] START_RESET = 8'h02;
  localparam logic [BYTE_W-1:0] STOP_RESET  = 8'h03;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE = 3'd0,
    REG_STOP_BYTE  = 3'd1,
    REG_MASK_Q0    = 3'd2,
    REG_MASK_Q1    = 3'd3,
    REG_MASK_Q2    = 3'd4,
    REG_MASK_Q3    = 3'd5
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_first;  // write the command byte at entry zero, fill count to one
    logic store_next;   // append the byte at the fill count
    logic load_first;   // fetch entry zero into the output register
    logic load_next;    // fetch the following entry into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_hit;    // received byte equals the start byte
    logic stop_hit;     // received byte equals the stop byte
    logic cmd_ok;       // received byte has its valid mask bit set
    logic store_full;   // store already holds its capacity
    logic at_last;      // output register holds the final byte of the frame
  } sts_t;

endpackage

[hw/rtl/cfd_ctrl.sv]
module cfd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  cfd_pkg::sts_t sts,
  output cfd_pkg::cmd_t cmd
);
  import cfd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AFTER_START,
    ST_COLLECT,
    ST_REPLAY
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;
  logic   out_fire;

  assign in_ready  = (state_r != ST_REPLAY);
  assign out_valid = (state_r == ST_REPLAY);
  assign in_fire   = in_valid & in_ready;
  assign out_fire  = out_valid & out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && sts.start_hit) begin
          state_nxt = ST_AFTER_START;
        end
      end
      ST_AFTER_START: begin
        if (in_fire) begin
          if (sts.cmd_ok) begin
            cmd.store_first = 1'b1;
            state_nxt       = ST_COLLECT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_COLLECT: begin
        // Stop takes priority over start when both are the same value.
        if (in_fire) begin
          if (sts.stop_hit) begin
            cmd.load_first = 1'b1;
            state_nxt      = ST_REPLAY;
          end else if (sts.start_hit) begin
            state_nxt = ST_AFTER_START;
          end else if (!sts.store_full) begin
            cmd.store_next = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REPLAY: begin
        if (out_fire) begin
          if (sts.at_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.load_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/cfd_datapath.sv]
module cfd_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [cfd_pkg::BYTE_W-1:0]         in_rx_byte,
  input  cfd_pkg::cmd_t                      cmd,
  output cfd_pkg::sts_t                      sts,
  output logic [cfd_pkg::BYTE_W-1:0]         out_frame_byte,
  output logic [cfd_pkg::LEN_W-1:0]          out_frame_length,
  output logic                               out_last_byte
);
  import cfd_pkg::*;

  logic [BYTE_W-1:0]                    start_byte_r;
  logic [BYTE_W-1:0]                    stop_byte_r;
  logic [MASK_WORDS-1:0][CFG_DATA_W-1:0] mask_r;
  logic [FILL_W-1:0]                    fill_count_r;
  logic [ADDR_W-1:0]                    rd_ptr_r;
  logic [ADDR_W-1:0]                    rd_addr;
  logic [BYTE_W-1:0]                    rd_data_r;
  logic [BYTE_W-1:0]                    store_mem [STORE_DEPTH];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_RESET;
      stop_byte_r  <= STOP_RESET;
      mask_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_BYTE: start_byte_r <= cfg_data[BYTE_W-1:0];
        REG_STOP_BYTE:  stop_byte_r  <= cfg_data[BYTE_W-1:0];
        REG_MASK_Q0:    mask_r[0]    <= cfg_data;
        REG_MASK_Q1:    mask_r[1]    <= cfg_data;
        REG_MASK_Q2:    mask_r[2]    <= cfg_data;
        REG_MASK_Q3:    mask_r[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sts.start_hit  = (in_rx_byte == start_byte_r);
  assign sts.stop_hit   = (in_rx_byte == stop_byte_r);
  assign sts.cmd_ok     = mask_r[in_rx_byte[7:6]][in_rx_byte[5:0]];
  assign sts.store_full = (fill_count_r == FILL_W'(STORE_DEPTH));
  assign sts.at_last    = ((FILL_W'(rd_ptr_r) + FILL_W'(1)) == fill_count_r);

  // Fill count and replay pointer.
  assign rd_addr = cmd.load_first ? '0 : (rd_ptr_r + ADDR_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      rd_ptr_r     <= '0;
    end else begin
      if (cmd.store_first) begin
        fill_count_r <= FILL_W'(1);
      end else if (cmd.store_next) begin
        fill_count_r <= fill_count_r + FILL_W'(1);
      end
      if (cmd.load_first || cmd.load_next) begin
        rd_ptr_r <= rd_addr;
      end
    end
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store_first) begin
      store_mem[0] <= in_rx_byte;
    end else if (cmd.store_next) begin
      store_mem[fill_count_r[ADDR_W-1:0]] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first || cmd.load_next) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign out_frame_byte   = rd_data_r;
  assign out_frame_length = LEN_W'(fill_count_r);
  assign out_last_byte    = sts.at_last;

endmodule

[hw/rtl/command_frame_deframer.sv]
// Command frame deframer.
//
// Received bytes enter on the in_ channel (valid/ready), one request each.
// A frame opens with the start byte, continues with a command byte whose bit
// is set in the 256-bit valid mask, then carries data bytes up to the stop
// byte. On the stop byte the stored frame is replayed on the out_ channel,
// command byte first, one request per byte, each carrying the frame length
// and a last flag on the final byte.
//
// Every byte that releases nothing is taken back to back. The stop byte
// hands control to the replay: the first frame byte appears in the cycle
// after the stop byte is taken, and further bytes follow one per cycle,
// while the receiver accepts them, from the single read port of the frame
// store. While a frame is replayed in_ready is low; it rises the cycle after
// the last frame byte is taken. A stalled receiver simply holds the current
// output byte in place.
// Reset (rst_n low, synchronous) returns the parser to idle, clears the fill
// count and loads start byte 2, stop byte 3 and an all-zero valid mask. The
// frame store itself is not cleared. The user writes configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
module command_frame_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cfd_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cfd_pkg::BYTE_W-1:0]     out_frame_byte,
  output logic [cfd_pkg::LEN_W-1:0]      out_frame_length,
  output logic                           out_last_byte
);
  import cfd_pkg::*;

  // Commands flow from the controller into the datapath; status flows back.
  cmd_t cmd;
  sts_t sts;

  cfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the fill count, the frame store
  // and the output byte register.
  cfd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_frame_byte   (out_frame_byte),
    .out_frame_length (out_frame_length),
    .out_last_byte    (out_last_byte)
  );

endmodule

[hw/rtl/cfd_checker.sv]
module cfd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cfd_pkg::BYTE_W-1:0] out_frame_byte,
  input logic [cfd_pkg::LEN_W-1:0]  out_frame_length,
  input logic                       out_last_byte
);

  // A stalled output request holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte)
      && $stable(out_frame_length) && $stable(out_last_byte))
    else $error("output request changed while stalled");

  // No new byte is taken while a frame is being replayed.
  a_no_in_during_replay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken during replay");

  // A replayed frame continues until its last byte.
  a_replay_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_byte |=> out_valid)
    else $error("replay stopped before last byte");

  // The replay ends right after its last byte is taken.
  a_replay_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_byte |=> !out_valid)
    else $error("output continued after last byte");

  // A released frame is never empty.
  a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_length != '0)
    else $error("empty frame released");

endmodule

bind command_frame_deframer cfd_checker u_cfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_byte   (out_frame_byte),
  .out_frame_length (out_frame_length),
  .out_last_byte    (out_last_byte)
);
